>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define PAM_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("assertion failed");

// implication checked on every rising clock edge outside reset
`define PAM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define PAM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

>>> rtl/core/pam_pkg.sv
`timescale 1ns / 1ps

package pam_pkg;

    localparam int COEF_W        = 32;
    localparam int EXP_W         = 16;
    localparam int MAX_TERMS_DEF = 32;
    localparam int QUEUE_DEPTH   = 4;

    // operation codes
    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_RUN         = 2'd2;

    typedef struct packed {
        logic [1:0]              operation;
        logic signed [COEF_W-1:0] coefficient;
        logic [EXP_W-1:0]        exponent;
    } in_t;

    typedef struct packed {
        logic signed [COEF_W-1:0] coefficient_res;
        logic [EXP_W-1:0]        exponent_res;
        logic                    last;
        logic                    empty_res;
        logic                    overflow;
    } out_t;

    // one stored polynomial term
    typedef struct packed {
        logic [COEF_W-1:0] coef;
        logic [EXP_W-1:0]  expo;
    } term_t;

    // command handed from the front queue to the back end
    typedef struct packed {
        logic [1:0] operation;
        term_t      term;
    } cmd_t;

endpackage

>>> rtl/core/pam_front.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pam_front (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pam_pkg::in_t   s_data,
    output logic           cmd_valid,
    output pam_pkg::cmd_t  cmd,
    input  logic           cmd_pop
);

    localparam int DEPTH = pam_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    pam_pkg::cmd_t  queue_mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           is_cmd;
    logic           push;
    logic           pop;

    // classify the incoming transaction: unknown operations are discarded
    assign is_cmd = (s_data.operation == pam_pkg::OP_LOAD_FIRST) ||
                    (s_data.operation == pam_pkg::OP_LOAD_SECOND) ||
                    (s_data.operation == pam_pkg::OP_RUN);

    assign s_ready   = (count_reg != CW'(DEPTH));
    assign push      = s_valid && s_ready && is_cmd;
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_pop && cmd_valid;
    assign cmd       = queue_mem[rd_ptr_reg];

    // pointer and fill count update
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_mem[wr_ptr_reg] <= '{operation: s_data.operation,
                                       term: '{coef: s_data.coefficient,
                                               expo: s_data.exponent}};
        end
    end

    `PAM_ASSERT(a_fill_bound, aclk, aresetn, count_reg <= CW'(DEPTH))
    `PAM_ASSERT_NXT(a_ignore_op, aclk, aresetn, s_valid && s_ready && !is_cmd && !pop, $stable(count_reg))

endmodule

>>> rtl/core/pam_back.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pam_back #(
    parameter int MAX_TERMS = pam_pkg::MAX_TERMS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cmd_valid,
    input  pam_pkg::cmd_t  cmd,
    output logic           cmd_pop,
    output logic           m_valid,
    input  logic           m_ready,
    output pam_pkg::out_t  m_data
);

    localparam int CNT_W = $clog2(MAX_TERMS + 1);
    localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_PRIME  = 2'd1;
    localparam logic [1:0] ST_MERGE  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    pam_pkg::term_t mem_a [MAX_TERMS];
    pam_pkg::term_t mem_b [MAX_TERMS];
    pam_pkg::term_t rd_a_reg, rd_b_reg;

    logic [1:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_a_reg, cnt_a_next;
    logic [CNT_W-1:0]  cnt_b_reg, cnt_b_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic              dropped_reg, dropped_next;
    pam_pkg::term_t    pend_reg, pend_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              m_valid_reg, m_valid_next;
    pam_pkg::out_t     out_reg, out_next;

    logic              out_free;
    logic              out_load;
    logic              wr_a, wr_b;
    logic              a_has, b_has;
    logic              take_a, take_b;
    logic [pam_pkg::COEF_W-1:0] tc;
    logic              term_nz;
    logic              stall;

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = out_reg;

    // head comparison of the two term lists
    assign a_has  = (i_reg < cnt_a_reg);
    assign b_has  = (j_reg < cnt_b_reg);
    assign take_a = a_has && (!b_has || (rd_a_reg.expo > rd_b_reg.expo));
    assign take_b = !take_a && (!a_has || (rd_a_reg.expo < rd_b_reg.expo));

    always_comb begin
        if (take_a) begin
            tc = rd_a_reg.coef;
        end else if (take_b) begin
            tc = rd_b_reg.coef;
        end else begin
            tc = rd_a_reg.coef + rd_b_reg.coef;
        end
    end

    assign term_nz = (tc != '0);
    assign stall   = term_nz && pend_valid_reg && !out_free;

    // loads write at the current fill count
    assign wr_a = (state_reg == ST_IDLE) && cmd_valid &&
                  (cmd.operation == pam_pkg::OP_LOAD_FIRST) &&
                  (cnt_a_reg != CNT_W'(MAX_TERMS));
    assign wr_b = (state_reg == ST_IDLE) && cmd_valid &&
                  (cmd.operation == pam_pkg::OP_LOAD_SECOND) &&
                  (cnt_b_reg != CNT_W'(MAX_TERMS));
    assign cmd_pop = (state_reg == ST_IDLE) && cmd_valid;

    // sequencer: execute loads, walk the merge, close the run
    always_comb begin
        state_next      = state_reg;
        cnt_a_next      = cnt_a_reg;
        cnt_b_next      = cnt_b_reg;
        i_next          = i_reg;
        j_next          = j_reg;
        dropped_next    = dropped_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_load        = 1'b0;
        out_next        = out_reg;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    case (cmd.operation)
                        pam_pkg::OP_LOAD_FIRST: begin
                            if (wr_a) begin
                                cnt_a_next = cnt_a_reg + 1'b1;
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        pam_pkg::OP_LOAD_SECOND: begin
                            if (wr_b) begin
                                cnt_b_next = cnt_b_reg + 1'b1;
                            end else begin
                                dropped_next = 1'b1;
                            end
                        end
                        pam_pkg::OP_RUN: begin
                            state_next = ST_PRIME;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_PRIME: begin
                state_next = ST_MERGE;
            end
            ST_MERGE: begin
                if (!a_has && !b_has) begin
                    state_next = ST_FINISH;
                end else if (!stall) begin
                    if (!take_b) begin
                        i_next = i_reg + 1'b1;
                    end
                    if (!take_a) begin
                        j_next = j_reg + 1'b1;
                    end
                    if (term_nz) begin
                        if (pend_valid_reg) begin
                            out_load = 1'b1;
                            out_next = '{coefficient_res: pend_reg.coef,
                                         exponent_res: pend_reg.expo,
                                         last: 1'b0, empty_res: 1'b0,
                                         overflow: dropped_reg};
                        end
                        pend_next       = '{coef: tc,
                                            expo: take_b ? rd_b_reg.expo : rd_a_reg.expo};
                        pend_valid_next = 1'b1;
                    end
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    out_load = 1'b1;
                    if (pend_valid_reg) begin
                        out_next = '{coefficient_res: pend_reg.coef,
                                     exponent_res: pend_reg.expo,
                                     last: 1'b1, empty_res: 1'b0,
                                     overflow: dropped_reg};
                    end else begin
                        out_next = '{coefficient_res: '0, exponent_res: '0,
                                     last: 1'b1, empty_res: 1'b1,
                                     overflow: dropped_reg};
                    end
                    cnt_a_next      = '0;
                    cnt_b_next      = '0;
                    i_next          = '0;
                    j_next          = '0;
                    dropped_next    = 1'b0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cnt_a_reg      <= '0;
            cnt_b_reg      <= '0;
            i_reg          <= '0;
            j_reg          <= '0;
            dropped_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cnt_a_reg      <= cnt_a_next;
            cnt_b_reg      <= cnt_b_next;
            i_reg          <= i_next;
            j_reg          <= j_next;
            dropped_reg    <= dropped_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

    // term stores, one write and one registered read each
    always_ff @(posedge aclk) begin
        if (wr_a) begin
            mem_a[cnt_a_reg[IDX_W-1:0]] <= cmd.term;
        end
        rd_a_reg <= mem_a[i_next[IDX_W-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (wr_b) begin
            mem_b[cnt_b_reg[IDX_W-1:0]] <= cmd.term;
        end
        rd_b_reg <= mem_b[j_next[IDX_W-1:0]];
    end

    `PAM_ASSERT(a_cnt_bound, aclk, aresetn, (cnt_a_reg <= CNT_W'(MAX_TERMS)) && (cnt_b_reg <= CNT_W'(MAX_TERMS)))
    `PAM_ASSERT_IMP(a_walk_bound, aclk, aresetn, state_reg == ST_MERGE, (i_reg <= cnt_a_reg) && (j_reg <= cnt_b_reg))
    `PAM_ASSERT_IMP(a_no_overwrite, aclk, aresetn, out_load && m_valid_reg, m_ready)
    `PAM_ASSERT_NXT(a_run_clears, aclk, aresetn, (state_reg == ST_FINISH) && out_free, (cnt_a_reg == '0) && (cnt_b_reg == '0) && !dropped_reg && m_valid_reg && m_data.last)

endmodule

>>> rtl/core/sparse_polynomial_add_merge_core.sv
// a load occupies the execution side only as it is dequeued; up to four commands queue ahead of it
// a run holds the execution side through the prime, merge and finish states plus output stalls,
// with one merge step per cycle while the output does not stall, over first_count + second_count
// steps less one for each pair of tied exponents
// the merge rate is set by the single registered read port of each term store
// synchronous active-low reset empties the queue, both stores, the overflow flag and the output
`timescale 1ns / 1ps

module sparse_polynomial_add_merge_core #(
    parameter int MAX_TERMS = pam_pkg::MAX_TERMS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  pam_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pam_pkg::out_t  m_data
);

    logic           cmd_valid;
    logic           cmd_pop;
    pam_pkg::cmd_t  cmd;

    // accept and classify transactions into the command queue
    pam_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // execute loads and merge runs
    pam_back #(
        .MAX_TERMS (MAX_TERMS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
